>>> src/utc_pkg.sv
// Shared types, codes and helpers of the Unicode transcoder.
// Used by utc_front, utc_queue, utc_back, unicode_transcoder and utc_checker.
package utc_pkg;

  // Encoding codes of the format registers (code 3 acts as UTF-32)
  localparam logic [1:0] FMT_UTF8  = 2'd0;
  localparam logic [1:0] FMT_UTF16 = 2'd1;
  localparam logic [1:0] FMT_UTF32 = 2'd2;

  // Register indexes on the configuration port
  localparam logic CFG_IN_FORMAT  = 1'b0;
  localparam logic CFG_OUT_FORMAT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ERR = 2'd1,
    ST_END = 2'd2
  } status_t;

  // Code point limits
  localparam logic [31:0] SURR_LO    = 32'h0000_D800;
  localparam logic [31:0] SURR_HI    = 32'h0000_DFFF;
  localparam logic [31:0] CODE_MAX   = 32'h0010_FFFF;
  localparam logic [31:0] TRAIL_BASE = 32'h0000_DC00;
  localparam logic [31:0] SUPP_BASE  = 32'h0001_0000;

  // One decoded event handed from the front to the back
  typedef struct packed {
    status_t     status;
    logic [20:0] code;
  } evt_t;

  // Scalar value check: no surrogates, nothing above the Unicode range
  function automatic logic code_ok(input logic [31:0] c);
    logic bad_surr;
    bad_surr = (c >= SURR_LO) && (c <= SURR_HI);
    return !bad_surr && (c <= CODE_MAX);
  endfunction

  // Event for a completed code point: valid code or one error result
  function automatic evt_t code_evt(input logic [31:0] c);
    evt_t e;
    if (code_ok(c)) begin
      e.status = ST_OK;
      e.code   = c[20:0];
    end else begin
      e.status = ST_ERR;
      e.code   = '0;
    end
    return e;
  endfunction

endpackage

>>> src/utc_front.sv
// Front end: accepts input code units, tracks partial sequences, produces events.
// Depends on utc_pkg.
module utc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_format,
  input  logic              flush,      // in_format write drops partial sequence
  input  logic              unit_acc,   // input transaction this cycle
  input  logic [31:0]       raw_unit,
  output logic              evt_valid,
  output utc_pkg::evt_t     evt
);

  logic [2:0]  pend_r, pend_nxt;
  logic [31:0] part_r, part_nxt;
  logic [31:0] unit;
  logic [31:0] cont_code;
  logic [31:0] trail;
  logic [31:0] pair_code;

  // Mask the unit to the width of the input encoding
  always_comb begin
    unique case (in_format)
      utc_pkg::FMT_UTF8:  unit = {24'd0, raw_unit[7:0]};
      utc_pkg::FMT_UTF16: unit = {16'd0, raw_unit[15:0]};
      default:            unit = raw_unit;
    endcase
  end

  // UTF-8 continuation and UTF-16 pair assembly
  assign cont_code = {part_r[25:0], unit[5:0]};
  assign trail     = unit - utc_pkg::TRAIL_BASE;
  assign pair_code = ({11'd0, part_r[10:0], 10'd0} | trail) + utc_pkg::SUPP_BASE;

  // Decode step
  always_comb begin
    pend_nxt  = pend_r;
    part_nxt  = part_r;
    evt_valid = 1'b0;
    evt       = '0;
    if (flush) begin
      pend_nxt = '0;
      part_nxt = '0;
    end else if (unit_acc) begin
      if (unit == '0) begin
        // end of string
        pend_nxt   = '0;
        part_nxt   = '0;
        evt_valid  = 1'b1;
        evt.status = utc_pkg::ST_END;
      end else if (in_format == utc_pkg::FMT_UTF8) begin
        if (pend_r != '0) begin
          part_nxt = cont_code;
          pend_nxt = pend_r - 3'd1;
          if (pend_r == 3'd1) begin
            evt_valid = 1'b1;
            evt       = utc_pkg::code_evt(cont_code);
          end
        end else if (unit[7] == 1'b0) begin
          evt_valid = 1'b1;
          evt       = utc_pkg::code_evt(unit);
        end else if (unit[7:5] == 3'b110) begin
          part_nxt = {27'd0, unit[4:0]};
          pend_nxt = 3'd1;
        end else if (unit[7:4] == 4'b1110) begin
          part_nxt = {28'd0, unit[3:0]};
          pend_nxt = 3'd2;
        end else if (unit[7:3] == 5'b11110) begin
          part_nxt = {29'd0, unit[2:0]};
          pend_nxt = 3'd3;
        end else if (unit[7:2] == 6'b111110) begin
          part_nxt = {30'd0, unit[1:0]};
          pend_nxt = 3'd4;
        end else if (unit[7:1] == 7'b1111110) begin
          part_nxt = {31'd0, unit[0]};
          pend_nxt = 3'd5;
        end else begin
          // stray continuation or 0xFE/0xFF lead
          evt_valid  = 1'b1;
          evt.status = utc_pkg::ST_ERR;
        end
      end else if (in_format == utc_pkg::FMT_UTF16) begin
        if (pend_r != '0) begin
          pend_nxt  = '0;
          part_nxt  = '0;
          evt_valid = 1'b1;
          evt       = utc_pkg::code_evt(pair_code);
        end else if ((unit >= utc_pkg::SURR_LO) && (unit <= utc_pkg::SURR_HI)) begin
          part_nxt = unit;
          pend_nxt = 3'd1;
        end else begin
          evt_valid = 1'b1;
          evt       = utc_pkg::code_evt(unit);
        end
      end else begin
        evt_valid = 1'b1;
        evt       = utc_pkg::code_evt(unit);
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

>>> src/utc_queue.sv
// Event queue between front and back end, a small register FIFO.
// Depends on utc_pkg.
module utc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utc_pkg::evt_t push_evt,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output utc_pkg::evt_t head_evt
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  utc_pkg::evt_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_evt   = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_evt;
    end
  end

endmodule

>>> src/utc_back.sv
// Back end: encodes queued events into output code units, one per cycle while out_tready is high.
// Depends on utc_pkg.
module utc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    out_format,
  input  logic          head_valid,
  input  utc_pkg::evt_t head_evt,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [20:0]   out_unit,
  output logic          out_last,
  output logic [1:0]    out_status
);

  logic [3:0][20:0] u;
  logic [1:0]       last_idx;
  logic [20:0]      c;
  logic [20:0]      d;
  logic             load;

  logic [1:0]       idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [20:0]      unit_r;
  logic             last_r;
  logic [1:0]       status_r;

  assign c = head_evt.code;
  assign d = c - 21'h10000;

  // Unit table of the head event in the output encoding
  always_comb begin
    u        = '0;
    last_idx = 2'd0;
    if (head_evt.status == utc_pkg::ST_OK) begin
      unique case (out_format)
        utc_pkg::FMT_UTF8: begin
          if (c <= 21'h7F) begin
            u[0] = c;
          end else if (c <= 21'h7FF) begin
            u[0]     = {13'd0, 3'b110, c[10:6]};
            u[1]     = {13'd0, 2'b10, c[5:0]};
            last_idx = 2'd1;
          end else if (c <= 21'hFFFF) begin
            u[0]     = {13'd0, 4'b1110, c[15:12]};
            u[1]     = {13'd0, 2'b10, c[11:6]};
            u[2]     = {13'd0, 2'b10, c[5:0]};
            last_idx = 2'd2;
          end else begin
            u[0]     = {13'd0, 5'b11110, c[20:18]};
            u[1]     = {13'd0, 2'b10, c[17:12]};
            u[2]     = {13'd0, 2'b10, c[11:6]};
            u[3]     = {13'd0, 2'b10, c[5:0]};
            last_idx = 2'd3;
          end
        end
        utc_pkg::FMT_UTF16: begin
          if (c < 21'h10000) begin
            u[0] = c;
          end else begin
            u[0]     = {5'd0, 6'b110110, d[19:10]};
            u[1]     = {5'd0, 6'b110111, d[9:0]};
            last_idx = 2'd1;
          end
        end
        default: u[0] = c;
      endcase
    end
  end

  // Output register loads when an event is queued and the register is empty or being drained
  assign load = head_valid && (!valid_r || out_tready);
  assign pop  = load && (idx_r == last_idx);

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = pop ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      unit_r   <= u[idx_r];
      last_r   <= (idx_r == last_idx);
      status_r <= head_evt.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_unit   = unit_r;
  assign out_last   = last_r;
  assign out_status = status_r;

endmodule

>>> src/unicode_transcoder.sv
// Unicode transcoder top level: register port, front end, event queue, back end.
// Depends on utc_pkg, utc_front, utc_queue, utc_back.
//
// Usage:
//   in_*   : stream of input code units (in_tdata = code_unit), one per transaction,
//            in the encoding set by register in_format (byte address 0).
//   out_*  : stream of output code units in the encoding set by out_format
//            (byte address 4); out_tlast marks the last unit caused by one input
//            unit, out_tuser carries the status (ok, error, end of string).
//   cfg_*  : register port, writes in the access phase, pready tied high, reads any time.
// A result reaches out_tvalid through the event queue and then the back end's output
// register, after the input transaction that completes its code point.
// Throughput: one input unit per cycle. A code point that needs n output units
// occupies the back end's output register until all n are taken; the QUEUE_DEPTH-entry
// event queue absorbs that, and in_tready drops only when the queue is full.
// Reset clears the formats to UTF-8 in / UTF-16 out, the partial sequence and
// the queue. When the receiver stalls, the output register holds its unit and
// the queue fills, after which input is stalled.
module unicode_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] code_unit
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [20:0] out_unit, [23:21] zero
  output logic        out_tlast,
  output logic [1:0]  out_tuser,    // [1:0] status
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0]    in_fmt_r;
  logic [1:0]    out_fmt_r;
  logic          cfg_wr;
  logic          flush;
  logic          unit_acc;
  logic          evt_valid;
  utc_pkg::evt_t evt;
  logic          q_full;
  logic          q_pop;
  logic          head_valid;
  utc_pkg::evt_t head_evt;
  logic [20:0]   out_unit;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign flush      = cfg_wr && (cfg_paddr[2] == utc_pkg::CFG_IN_FORMAT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_fmt_r  <= utc_pkg::FMT_UTF8;
      out_fmt_r <= utc_pkg::FMT_UTF16;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == utc_pkg::CFG_IN_FORMAT) begin
        in_fmt_r <= cfg_pwdata[1:0];
      end else begin
        out_fmt_r <= cfg_pwdata[1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == utc_pkg::CFG_IN_FORMAT) ?
                      {30'd0, in_fmt_r} : {30'd0, out_fmt_r};

  // Input handshake
  assign in_tready = !q_full;
  assign unit_acc  = in_tvalid && in_tready;

  utc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_format (in_fmt_r),
    .flush     (flush),
    .unit_acc  (unit_acc),
    .raw_unit  (in_tdata),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  utc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (evt_valid),
    .push_evt   (evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_evt   (head_evt)
  );

  utc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_format (out_fmt_r),
    .head_valid (head_valid),
    .head_evt   (head_evt),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_unit   (out_unit),
    .out_last   (out_tlast),
    .out_status (out_tuser)
  );

  assign out_tdata = {3'd0, out_unit};

endmodule

>>> src/utc_checker.sv
// Port-level checker for the Unicode transcoder, bound to the top level.
// Depends on utc_pkg and unicode_transcoder.
module utc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output changed while stalled");

  // Error and end results are single, zero-valued and closing
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != utc_pkg::ST_OK) |-> (out_tdata == '0) && out_tlast)
    else $error("error or end result not a single zero unit");

  // Valid units stay inside the Unicode range
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == utc_pkg::ST_OK) |-> (out_tdata <= 24'h10FFFF))
    else $error("output unit out of range");

  // Nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind unicode_transcoder utc_checker u_utc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
